// ----- sv/lzs_pkg.sv -----
// ----------------------------------------------------------------------------
// LZS decompressor package
// Shared constants and result codes of the LZS stream decompressor.
// ----------------------------------------------------------------------------
package lzs_pkg;

  localparam int WindowSize = 2048;
  localparam int PtrW       = $clog2(WindowSize);
  localparam int CntW       = PtrW + 1;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  typedef enum logic [6:0] {
    PH_FLAG      = 7'b0000001,
    PH_LIT       = 7'b0000010,
    PH_TAG       = 7'b0000100,
    PH_OFF_SHORT = 7'b0001000,
    PH_OFF_LONG  = 7'b0010000,
    PH_LEN2      = 7'b0100000,
    PH_NIB       = 7'b1000000
  } phase_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_BIT  = 5'b00010,
    ST_RD   = 5'b00100,
    ST_CPY  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

endpackage

// ----- sv/lzs_stream_decompressor.sv -----
// ----------------------------------------------------------------------------
// LZS stream decompressor
// Parses a compressed LZS byte stream bit by bit and emits the decompressed
// bytes through a history memory, plus end and error markers.
// ----------------------------------------------------------------------------
//   Channel   Direction  Fields
//   in_       input      in_byte, in_start_stream
//   out_      output     out_byte, out_kind, out_last_of_run
//
// An input transaction that copies nothing is accepted in ST_IDLE, parsed bit
// by bit in ST_BIT and closed by handing over its last result. A byte after
// an end or an error is dropped in ST_IDLE unless it starts a new stream. A
// copy reads a byte in ST_RD, writes it in ST_CPY and passes ST_OUT between bytes.
// Results pass through a pending register into the output register; parsing
// and copying pause while the output register is full. Reset is synchronous
// and active low; the history memory is not cleared.
module lzs_stream_decompressor
  import lzs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_start_stream,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       out_last_of_run
);

  logic [7:0] hist_mem [WindowSize];
  logic [7:0] rd_data_r;

  state_t          state_r;
  phase_t          phase_r;
  logic [7:0]      sh_r;
  logic [3:0]      bitcnt_r;
  logic [PtrW-1:0] acc_r;
  logic [3:0]      rem_r;
  logic [PtrW-1:0] wp_r, cp_r;
  logic [CntW-1:0] prod_r;
  logic [3:0]      len_r;
  logic [3:0]      copies_r;
  logic            done_r;
  logic            ov_r;
  logic            pend_r;
  logic [7:0]      pend_byte_r;
  logic [1:0]      pend_kind_r;

  logic [PtrW-1:0] acc_nxt;
  logic            bit_in;
  logic            bit_go, byte_end, field_end;
  logic            off_zero, off_big;
  logic            res_lit, res_end, res_err, res_cpy, res_new;
  logic            push_mid, push_last;
  logic [7:0]      res_byte;
  logic [1:0]      res_kind;

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = ov_r;
  assign bit_in = sh_r[7];
  assign acc_nxt = {acc_r[PtrW-2:0], bit_in};

  assign bit_go = (state_r == ST_BIT) && !ov_r && (bitcnt_r != 4'd0) && !done_r;
  assign byte_end = (state_r == ST_BIT) && (!ov_r || out_ready) &&
                    (bitcnt_r == 4'd0 || done_r);
  assign field_end = bit_go && (phase_r != PH_FLAG) && (phase_r != PH_TAG) &&
                     (rem_r <= 4'd1);
  assign off_zero = (acc_nxt == '0);
  assign off_big = (CntW'(acc_nxt) > prod_r);
  assign res_lit = field_end && (phase_r == PH_LIT);
  assign res_end = field_end && (phase_r == PH_OFF_SHORT) && off_zero;
  assign res_err = field_end && (phase_r == PH_OFF_SHORT || phase_r == PH_OFF_LONG) &&
                   !res_end && (off_zero || off_big);
  assign res_cpy = (state_r == ST_CPY) && !ov_r;
  assign res_new = res_lit || res_end || res_err || res_cpy;
  assign push_mid = res_new && pend_r;
  assign push_last = byte_end && pend_r;
  assign res_byte = res_cpy ? rd_data_r : (res_lit ? acc_nxt[7:0] : 8'h00);
  assign res_kind = res_end ? KIND_END : (res_err ? KIND_ERR : KIND_DATA);

  always_ff @(posedge clk) begin
    if (res_lit || res_cpy) begin
      hist_mem[wp_r] <= res_byte;
    end
    rd_data_r <= hist_mem[cp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      phase_r  <= PH_FLAG;
      acc_r    <= '0;
      rem_r    <= '0;
      wp_r     <= '0;
      cp_r     <= '0;
      prod_r   <= '0;
      len_r    <= '0;
      copies_r <= '0;
      done_r   <= 1'b0;
      ov_r     <= 1'b0;
      bitcnt_r <= '0;
      pend_r   <= 1'b0;
    end else begin
      ov_r <= push_mid || push_last || (ov_r && !out_ready);
      if (push_mid || push_last) begin
        out_byte        <= pend_byte_r;
        out_kind        <= pend_kind_r;
        out_last_of_run <= push_last;
      end
      if (res_new) begin
        pend_r      <= 1'b1;
        pend_byte_r <= res_byte;
        pend_kind_r <= res_kind;
      end else if (push_last) begin
        pend_r <= 1'b0;
      end
      if (res_lit || res_cpy) begin
        wp_r <= wp_r + PtrW'(1);
        if (prod_r != CntW'(WindowSize)) prod_r <= prod_r + CntW'(1);
      end
      if (res_end || res_err) begin
        done_r <= 1'b1;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            sh_r     <= in_byte;
            bitcnt_r <= 4'd8;
            if (in_start_stream) begin
              phase_r <= PH_FLAG;
              acc_r   <= '0;
              rem_r   <= '0;
              wp_r    <= '0;
              cp_r    <= '0;
              prod_r  <= '0;
              len_r   <= '0;
              done_r  <= 1'b0;
              state_r <= ST_BIT;
            end else if (!done_r) begin
              state_r <= ST_BIT;
            end
          end
        end
        ST_BIT: begin
          if (byte_end) begin
            state_r <= ST_IDLE;
          end else if (bit_go) begin
            sh_r     <= {sh_r[6:0], 1'b0};
            bitcnt_r <= bitcnt_r - 4'd1;
            unique case (phase_r)
              PH_FLAG: begin
                phase_r <= bit_in ? PH_TAG : PH_LIT;
                acc_r   <= '0;
                rem_r   <= bit_in ? 4'd1 : 4'd8;
              end
              PH_TAG: begin
                phase_r <= bit_in ? PH_OFF_SHORT : PH_OFF_LONG;
                acc_r   <= '0;
                rem_r   <= bit_in ? 4'd7 : 4'd11;
              end
              default: begin
                if (rem_r > 4'd1) begin
                  acc_r <= acc_nxt;
                  rem_r <= rem_r - 4'd1;
                end else begin
                  rem_r <= '0;
                  acc_r <= '0;
                  if (phase_r == PH_LIT) begin
                    phase_r <= PH_FLAG;
                  end else if (phase_r == PH_OFF_SHORT || phase_r == PH_OFF_LONG) begin
                    if (!res_end && !res_err) begin
                      cp_r     <= wp_r - acc_nxt;
                      copies_r <= 4'd2;
                      len_r    <= 4'd2;
                      phase_r  <= PH_LEN2;
                      rem_r    <= 4'd2;
                      state_r  <= ST_RD;
                    end
                  end else if (phase_r == PH_LEN2) begin
                    copies_r <= {2'b00, acc_nxt[1:0]};
                    len_r    <= len_r + {2'b00, acc_nxt[1:0]};
                    if (acc_nxt[1:0] == 2'd3 && (len_r + 4'd3) < 4'd8) begin
                      phase_r <= PH_LEN2; rem_r <= 4'd2;
                    end else if (len_r + {2'b00, acc_nxt[1:0]} == 4'd8) begin
                      phase_r <= PH_NIB; rem_r <= 4'd4;
                    end else begin
                      phase_r <= PH_FLAG;
                    end
                    if (acc_nxt[1:0] != 2'd0) state_r <= ST_RD;
                  end else begin
                    copies_r <= acc_nxt[3:0];
                    if (acc_nxt[3:0] == 4'd15) begin
                      phase_r <= PH_NIB; rem_r <= 4'd4;
                    end else begin
                      phase_r <= PH_FLAG;
                    end
                    if (acc_nxt[3:0] != 4'd0) state_r <= ST_RD;
                  end
                end
              end
            endcase
          end
        end
        ST_RD: begin
          state_r <= ST_CPY;
        end
        ST_CPY: begin
          if (!ov_r) begin
            cp_r     <= cp_r + PtrW'(1);
            copies_r <= copies_r - 4'd1;
            state_r  <= (copies_r == 4'd1) ? ST_BIT : ST_OUT;
          end
        end
        ST_OUT: begin
          state_r <= ST_RD;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
